// ----- rtl/core/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared constants, request and status codes, and the per-cell control
// struct used by the list cells and the top level.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Default sizes of the list.
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Width of positions, counts and cell indexes inside the chain. It holds
  // the largest capacity plus one and the largest 5-bit position plus one.
  localparam int unsigned CMP_W = 10;

  // Field widths of the stream items.
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_LOCATE = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_e;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    cell_op_e           op;     // shift applied at this clock edge
    logic [CMP_W-1:0]   sel;    // 0-based position of the request
    logic [CMP_W-1:0]   count;  // entries held before the request
  } cell_ctrl_t;

endpackage

// ----- rtl/core/positional_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of up to CAPACITY signed words with insert, delete, read
// and locate requests, built as a row of cells that shift together.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  tdata fields, lowest bit first
//   s_axis   in         mode[1:0], position[6:2], value[38:7], zero pad
//   m_axis   out        status[1:0], result_value[33:2],
//                       found_position[38:34], list_length[43:39], zero pad
//
// A request is handled whole when it is accepted: it is decoded, the cells shift or
// compare, and the answer lands in the output register at the same edge.
// The read data and the first-match position ripple through the cell row,
// so the length of that chain sets the clock period.
// Reset empties the list; the entries themselves are not cleared.
// A new item is taken whenever the output register is empty or is being
// drained in the same cycle, so a stalled output holds off the input.
//
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY   = ple_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // mode[1:0], position[6:2], value[38:7], zero pad
  input  logic [ple_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[1:0], result_value[33:2], found_position[38:34],
  // list_length[43:39], zero pad
  output logic [ple_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import ple_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Input item fields.
  mode_e                     mode;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] value;
  logic                      in_acc;

  // Extended request word, kept in the low DATA_WIDTH bits.
  logic signed [63:0]        value_ext;
  logic [DATA_WIDTH-1:0]     word_in;

  // Comparison copies of position and count.
  logic [CMP_W-1:0]          pos_c, cnt_c, cap_c;

  // List length and output register.
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      out_valid_q;
  logic [OUT_TDATA_W-1:0]    out_data_q;

  // Request decode results.
  status_e                   req_status;
  status_e                   status;
  cell_ctrl_t                ctrl;
  logic                      rval_en;
  logic                      found_en;

  // Cell row.
  logic [DATA_WIDTH-1:0]     words [CAPACITY];
  logic                      seen  [CAPACITY+1];
  logic [CMP_W-1:0]          found [CAPACITY+1];
  logic [DATA_WIDTH-1:0]     data  [CAPACITY+1];

  // Result fields.
  logic signed [63:0]        rval_ext;
  logic [VALUE_W-1:0]        result_value;
  logic [POS_W-1:0]          found_position;
  logic [LEN_W-1:0]          list_length;

  assign mode     = mode_e'(s_axis_tdata[MODE_W-1:0]);
  assign position = s_axis_tdata[MODE_W +: POS_W];
  assign value    = s_axis_tdata[MODE_W+POS_W +: VALUE_W];

  assign value_ext = 64'(value);
  assign word_in   = value_ext[DATA_WIDTH-1:0];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign pos_c = CMP_W'(position);
  assign cnt_c = CMP_W'(count_q);
  assign cap_c = CMP_W'(CAPACITY);

  // Request decode: bounds checks pick the status, and only a request that
  // succeeds and is accepted this cycle moves the cells or the count.
  always_comb begin
    req_status = ST_OK;
    ctrl.op    = CELL_HOLD;
    ctrl.sel   = pos_c - CMP_W'(1);
    ctrl.count = cnt_c;
    count_d    = count_q;
    rval_en    = 1'b0;
    found_en   = 1'b0;
    unique case (mode)
      MODE_INSERT: begin
        if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) begin
          req_status = ST_RANGE;
        end else if (cnt_c >= cap_c) begin
          req_status = ST_FULL;
        end else begin
          ctrl.op = in_acc ? CELL_INSERT : CELL_HOLD;
          count_d = count_q + CNT_W'(1);
        end
      end
      MODE_DELETE, MODE_READ: begin
        if (pos_c == '0 || pos_c > cnt_c) begin
          req_status = ST_RANGE;
        end else begin
          rval_en = 1'b1;
          if (mode == MODE_DELETE) begin
            ctrl.op = in_acc ? CELL_DELETE : CELL_HOLD;
            count_d = count_q - CNT_W'(1);
          end
        end
      end
      MODE_LOCATE: begin
        found_en = 1'b1;
      end
      default: req_status = ST_OK;
    endcase
  end

  // A locate that finds no match anywhere in the row reports the value
  // as missing.
  assign status = (found_en && found[CAPACITY] == '0) ? ST_MISSING : req_status;

  // The chain starts with no match seen, no position and no data.
  assign seen[0]  = 1'b0;
  assign found[0] = '0;
  assign data[0]  = '0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;

    // The first cell never takes from its left neighbor and the last cell
    // keeps its own word when the list shifts down.
    if (k == 0) begin : g_first
      assign left_w = word_in;
    end else begin : g_inner_l
      assign left_w = words[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = words[k];
    end else begin : g_inner_r
      assign right_w = words[k+1];
    end

    ple_cell #(
      .IDX        (k),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .ins_i   (word_in),
      .key_i   (word_in),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (words[k]),
      .seen_i  (seen[k]),
      .seen_o  (seen[k+1]),
      .found_i (found[k]),
      .found_o (found[k+1]),
      .data_i  (data[k]),
      .data_o  (data[k+1])
    );
  end

  // The stored word is sign-extended back to the 32-bit result field.
  assign rval_ext       = 64'($signed(data[CAPACITY]));
  assign result_value   = rval_en ? rval_ext[VALUE_W-1:0] : '0;
  assign found_position = found_en ? found[CAPACITY][POS_W-1:0] : '0;
  assign list_length    = LEN_W'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= OUT_TDATA_W'({list_length, found_position, result_value, status});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- rtl/core/ple_cell.sv -----
// ----------------------------------------------------------------------------
// Positional list engine cell
// Holds one list entry. Shifts with its neighbors on insert and delete,
// and passes the read data and the first-match position down the chain.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  ple_pkg::cell_ctrl_t          ctrl_i,
  input  logic [DATA_WIDTH-1:0]        ins_i,
  input  logic [DATA_WIDTH-1:0]        key_i,
  input  logic [DATA_WIDTH-1:0]        left_i,
  input  logic [DATA_WIDTH-1:0]        right_i,
  output logic [DATA_WIDTH-1:0]        word_o,
  input  logic                         seen_i,
  output logic                         seen_o,
  input  logic [ple_pkg::CMP_W-1:0]    found_i,
  output logic [ple_pkg::CMP_W-1:0]    found_o,
  input  logic [DATA_WIDTH-1:0]        data_i,
  output logic [DATA_WIDTH-1:0]        data_o
);
  import ple_pkg::*;

  localparam logic [CMP_W-1:0] K  = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] K1 = CMP_W'(IDX + 1);

  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic                  match, first, hit;

  assign match = (word_q == key_i) && (K < ctrl_i.count);
  assign first = match && !seen_i;
  assign hit   = (K == ctrl_i.sel);

  assign word_o  = word_q;
  assign seen_o  = seen_i | match;
  assign found_o = first ? K1 : found_i;
  assign data_o  = hit ? word_q : data_i;

  always_comb begin
    word_d = word_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (K > ctrl_i.sel) begin
          word_d = left_i;
        end else if (K == ctrl_i.sel) begin
          word_d = ins_i;
        end
      end
      CELL_DELETE: begin
        if (K >= ctrl_i.sel) begin
          word_d = right_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

// ----- verif/positional_list_engine_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives insert, delete, read and locate requests into the list engine over
// its input stream and checks every answer against a predictor of the list,
// with random idle cycles on both streams and long output back-pressure.
// ----------------------------------------------------------------------------
module positional_list_engine_unit_tb;
  import ple_pkg::*;

  localparam int LIST_DEPTH   = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1130;

  // The fields of one request as carried in s_axis_tdata, and of one answer
  // as carried in m_axis_tdata.
  typedef struct packed {
    mode_e             mode;
    logic [POS_W-1:0]  position;
    logic [VALUE_W-1:0] value;
  } list_request_t;

  typedef struct packed {
    status_e            status;
    logic [VALUE_W-1:0] result_value;
    logic [LEN_W-1:0]   found_position;
    logic [LEN_W-1:0]   list_length;
  } list_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Requests waiting to be offered, and answers the predictor expects.
  list_request_t pending_requests[$];
  list_result_t  expected_results[$];

  // Predicted contents of the list.
  logic [VALUE_W-1:0] held_words[LIST_DEPTH];
  int                 held_count = 0;

  // Length the request generator assumes, used to aim positions.
  int planned_len = 0;

  int mismatch_count = 0;
  int results_seen   = 0;
  int requests_taken = 0;
  bit request_taken  = 1'b0;

  int tx_gap = 0;
  int tx_calm = 0;
  int rx_gap = 0;
  int rx_calm = 0;
  int backpressure_left = 0;
  int next_backpressure_at = 200;
  list_request_t next_request;

  positional_list_engine_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Applies one request to the predicted list and returns its answer.
  function automatic list_result_t apply_list_request(input list_request_t req);
    list_result_t res;
    int pos;
    res.status         = ST_OK;
    res.result_value   = '0;
    res.found_position = '0;
    pos = int'(req.position);
    case (req.mode)
      MODE_INSERT: begin
        // The position check wins over the full check.
        if (pos < 1 || pos > held_count + 1) begin
          res.status = ST_RANGE;
        end else if (held_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int k = held_count; k >= pos; k--) held_words[k] = held_words[k-1];
          held_words[pos-1] = req.value;
          held_count++;
        end
      end
      MODE_DELETE, MODE_READ: begin
        if (pos < 1 || pos > held_count) begin
          res.status = ST_RANGE;
        end else begin
          res.result_value = held_words[pos-1];
          if (req.mode == MODE_DELETE) begin
            for (int k = pos; k < held_count; k++) held_words[k-1] = held_words[k];
            held_count--;
          end
        end
      end
      default: begin
        // Locate reports the first match only.
        res.status = ST_MISSING;
        for (int k = 0; k < held_count; k++) begin
          if (res.status == ST_MISSING && held_words[k] == req.value) begin
            res.status         = ST_OK;
            res.found_position = LEN_W'(k + 1);
          end
        end
      end
    endcase
    res.list_length = LEN_W'(held_count);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on answer %0d: %s got %0h expected %0h",
             $realtime, results_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_list_result(input logic [OUT_TDATA_W-1:0] word);
    list_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("answer with nothing outstanding", word[31:0], '0);
    end else begin
      want = expected_results.pop_front();
      if (word[1:0] != want.status)
        report_mismatch("status", word[1:0], want.status);
      if (word[33:2] != want.result_value)
        report_mismatch("result_value", word[33:2], want.result_value);
      if (word[38:34] != want.found_position)
        report_mismatch("found_position", word[38:34], want.found_position);
      if (word[43:39] != want.list_length)
        report_mismatch("list_length", word[43:39], want.list_length);
      if (word[OUT_TDATA_W-1:44] != '0)
        report_mismatch("padding", word[OUT_TDATA_W-1:44], '0);
    end
    results_seen++;
  endtask

  // Idle lengths: mostly none or short, now and then a long one, and
  // occasionally a calm stretch with no idling at all.
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) calm = $urandom_range(40, 150);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Queues one request and tracks the length it leaves behind, so later
  // positions can be aimed at the live part of the list.
  task automatic queue_request(input mode_e mode, input int pos,
                               input logic [31:0] value);
    list_request_t req;
    req.mode     = mode;
    req.position = pos[POS_W-1:0];
    req.value    = value;
    pending_requests.push_back(req);
    case (mode)
      MODE_INSERT:
        if (pos >= 1 && pos <= planned_len + 1 && planned_len < LIST_DEPTH) planned_len++;
      MODE_DELETE:
        if (pos >= 1 && pos <= planned_len) planned_len--;
      default: ;
    endcase
  endtask

  // Monitor: both handshakes are sampled at the rising edge. The answer is
  // checked before the new request is predicted, so a result leaving in the
  // same cycle is matched against the older expectation.
  always @(posedge clk_i) begin
    request_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_list_result(m_axis_tdata);
    if (request_taken) begin
      next_request.mode     = mode_e'(s_axis_tdata[1:0]);
      next_request.position = s_axis_tdata[6:2];
      next_request.value    = s_axis_tdata[38:7];
      expected_results.push_back(apply_list_request(next_request));
      requests_taken++;
    end
  end

  // Driver: a new item is presented at the falling edge once the previous
  // one was taken, after a random gap.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || request_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        next_request = pending_requests.pop_front();
        s_axis_tdata  <= {1'b0, next_request.value, next_request.position,
                          next_request.mode};
        s_axis_tvalid <= 1'b1;
        tx_gap = pick_gap(tx_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random ready gaps, plus a long hold-off twice in the run so
  // the output register stays full and the input stream stalls.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (backpressure_left > 0) begin
      backpressure_left--;
      m_axis_tready <= 1'b0;
    end else if (requests_taken >= next_backpressure_at) begin
      backpressure_left = 120;
      next_backpressure_at += 500;
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      rx_gap = pick_gap(rx_calm);
    end
  end

  // Timeout guard.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [31:0] value_pool[8];
    int          episode_left;
    int          bias;
    int          roll;
    int          pos;
    mode_e       mode;
    logic [31:0] value;

    // Directed part: empty-list errors, bad insert positions, extreme
    // values, head, middle and tail edits, a duplicate, locate hit and miss.
    queue_request(MODE_READ,   1, 32'h0);
    queue_request(MODE_DELETE, 1, 32'h0);
    queue_request(MODE_LOCATE, 0, 32'h0);
    queue_request(MODE_INSERT, 0, 32'h1234_5678);
    queue_request(MODE_INSERT, 2, 32'h1234_5678);
    queue_request(MODE_INSERT, 1, 32'h8000_0000);
    queue_request(MODE_INSERT, 2, 32'h7FFF_FFFF);
    queue_request(MODE_INSERT, 1, 32'hFFFF_FFFF);
    queue_request(MODE_INSERT, 2, 32'h0000_0000);
    queue_request(MODE_INSERT, 5, 32'h7FFF_FFFF);
    queue_request(MODE_LOCATE, 31, 32'h7FFF_FFFF);
    queue_request(MODE_LOCATE, 3, 32'h0000_3039);
    queue_request(MODE_READ,   5, 32'h0);
    queue_request(MODE_READ,   6, 32'h0);
    queue_request(MODE_READ,  31, 32'hFFFF_FFFF);
    queue_request(MODE_INSERT, 31, 32'h5555_AAAA);
    queue_request(MODE_DELETE, 0, 32'h0);
    queue_request(MODE_DELETE, 5, 32'h0);
    queue_request(MODE_DELETE, 1, 32'h0);
    queue_request(MODE_DELETE, 2, 32'h0);
    queue_request(MODE_LOCATE, 16, 32'h8000_0000);

    // Random part in episodes that grow the list toward full, drain it
    // toward empty, or mix. Values come mostly from a small pool so that
    // locate hits and duplicate entries are common.
    value_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                   $urandom, $urandom, $urandom, $urandom};
    episode_left = 0;
    bias = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (episode_left == 0) begin
        episode_left = $urandom_range(20, 80);
        bias = $urandom_range(0, 2);
        for (int k = 4; k < 8; k++) value_pool[k] = $urandom;
      end
      episode_left--;
      roll = $urandom_range(0, 99);
      case (bias)
        0:       mode = roll < 60 ? MODE_INSERT : roll < 70 ? MODE_DELETE :
                        roll < 85 ? MODE_READ : MODE_LOCATE;
        1:       mode = roll < 15 ? MODE_INSERT : roll < 65 ? MODE_DELETE :
                        roll < 85 ? MODE_READ : MODE_LOCATE;
        default: mode = roll < 30 ? MODE_INSERT : roll < 55 ? MODE_DELETE :
                        roll < 78 ? MODE_READ : MODE_LOCATE;
      endcase
      // Mostly valid positions, some anywhere in the 5-bit range.
      if (mode == MODE_LOCATE || $urandom_range(0, 9) < 2)
        pos = $urandom_range(0, 31);
      else if (mode == MODE_INSERT)
        pos = $urandom_range(1, planned_len + 1);
      else if (planned_len == 0)
        pos = $urandom_range(0, 31);
      else
        pos = $urandom_range(1, planned_len);
      value = $urandom_range(0, 9) < 6 ? value_pool[$urandom_range(0, 7)] : $urandom;
      queue_request(mode, pos, value);
    end

    // Reset once, released at a falling edge.
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0);

    // Run on past the last answer so that a stray extra answer would still be seen.
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("answers still outstanding", expected_results.size(), 0);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ple_pkg.sv
rtl/core/ple_cell.sv
rtl/core/positional_list_engine_unit.sv
verif/positional_list_engine_unit_tb.sv
